// ----- rtl/dip_pkg.sv -----
// ----------------------------------------------------------------------------
// dip_pkg: shared types and constants of the decimal integer parser
// Character codes, mode codes, range limits and the beat bundles that pass
// between the pipeline stages.
// ----------------------------------------------------------------------------
package dip_pkg;

  typedef enum logic [1:0] {
    MODE_S64 = 2'd0,
    MODE_S32 = 2'd1,
    MODE_U64 = 2'd2,
    MODE_U32 = 2'd3
  } mode_t;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [63:0] LIM_S64_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_S64_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] LIM_U64     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_S32_POS = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] LIM_S32_NEG = 64'h0000_0000_8000_0000;
  localparam logic [63:0] LIM_U32     = 64'h0000_0000_FFFF_FFFF;

  // Per-digit overflow bounds: the magnitude may grow by one digit only if
  // it stays at or below limit / 10, with the last digit at most limit % 10.
  localparam logic [63:0] QUO_S64_POS = LIM_S64_POS / 64'd10;
  localparam logic [3:0]  REM_S64_POS = 4'(LIM_S64_POS % 64'd10);
  localparam logic [63:0] QUO_S64_NEG = LIM_S64_NEG / 64'd10;
  localparam logic [3:0]  REM_S64_NEG = 4'(LIM_S64_NEG % 64'd10);
  localparam logic [63:0] QUO_U64     = LIM_U64 / 64'd10;
  localparam logic [3:0]  REM_U64     = 4'(LIM_U64 % 64'd10);

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       last_char;
  } item_t;

  // Everything the result stage needs to finish one number.
  typedef struct packed {
    logic [63:0] acc;
    logic        minus;
    logic        ok_pre;
    mode_t       mode;
  } fin_t;

endpackage

// ----- rtl/dip_in_stage.sv -----
// ----------------------------------------------------------------------------
// dip_in_stage: input register of the decimal integer parser
// Holds one character beat and refills in the cycle the core takes it.
// ----------------------------------------------------------------------------
module dip_in_stage
  import dip_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  item_valid,
  output item_t item,
  input  logic  item_take
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- rtl/dip_core.sv -----
// ----------------------------------------------------------------------------
// dip_core: per-character parse step of the decimal integer parser
// Keeps the running magnitude and sign state, checks each digit against the
// mode's 64-bit limit, and hands the finished number to the result stage.
// ----------------------------------------------------------------------------
module dip_core
  import dip_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  mode_t mode,
  input  logic  item_valid,
  input  item_t item,
  output logic  item_take,
  output logic  fin_valid,
  output fin_t  fin,
  input  logic  fin_ready_out
);

  logic [63:0] acc_r, acc_nxt;
  logic        minus_r, minus_nxt;
  logic        first_r, first_nxt;
  logic        digit_r, digit_nxt;
  logic        rej_r, rej_nxt;
  logic        fin_valid_r, fin_valid_nxt;
  fin_t        fin_r, fin_nxt;

  logic        fin_ready;
  logic [63:0] acc_w;
  logic        minus_w, digit_w, rej_w;
  logic [3:0]  dval;
  logic [63:0] quo;
  logic [3:0]  rem;
  logic [63:0] mul10;

  assign fin_ready = !fin_valid_r || fin_ready_out;
  assign item_take = item_valid && (!item.last_char || fin_ready);
  assign fin_valid = fin_valid_r;
  assign fin       = fin_r;

  assign dval  = 4'(item.char_code - CH_ZERO);
  assign mul10 = {acc_r[60:0], 3'b000} + {acc_r[62:0], 1'b0} + 64'(dval);

  always_comb begin
    if (mode[1]) begin
      quo = QUO_U64;
      rem = REM_U64;
    end else if (minus_r) begin
      quo = QUO_S64_NEG;
      rem = REM_S64_NEG;
    end else begin
      quo = QUO_S64_POS;
      rem = REM_S64_POS;
    end
  end

  // Effect of this beat's character on the parse state.
  always_comb begin
    acc_w   = acc_r;
    minus_w = minus_r;
    digit_w = digit_r;
    rej_w   = rej_r;
    if (item.has_char && !rej_r) begin
      if (first_r && item.char_code == CH_MINUS) begin
        if (mode[1]) begin
          rej_w = 1'b1;
        end else begin
          minus_w = 1'b1;
        end
      end else if (first_r && item.char_code == CH_PLUS) begin
        rej_w = rej_r;
      end else if (!(item.char_code inside {[CH_ZERO:CH_NINE]})) begin
        rej_w = 1'b1;
      end else if (acc_r > quo || (acc_r == quo && dval > rem)) begin
        rej_w = 1'b1;
      end else begin
        acc_w   = mul10;
        digit_w = 1'b1;
      end
    end
  end

  always_comb begin
    acc_nxt       = acc_r;
    minus_nxt     = minus_r;
    first_nxt     = first_r;
    digit_nxt     = digit_r;
    rej_nxt       = rej_r;
    fin_valid_nxt = fin_valid_r;
    fin_nxt       = fin_r;
    if (fin_ready) begin
      fin_valid_nxt = item_take && item.last_char;
    end
    if (item_take) begin
      if (item.last_char) begin
        fin_nxt.acc    = acc_w;
        fin_nxt.minus  = minus_w;
        fin_nxt.ok_pre = digit_w && !rej_w;
        fin_nxt.mode   = mode;
        acc_nxt        = '0;
        minus_nxt      = 1'b0;
        first_nxt      = 1'b1;
        digit_nxt      = 1'b0;
        rej_nxt        = 1'b0;
      end else begin
        acc_nxt   = acc_w;
        minus_nxt = minus_w;
        digit_nxt = digit_w;
        rej_nxt   = rej_w;
        if (item.has_char) begin
          first_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      minus_r     <= 1'b0;
      first_r     <= 1'b1;
      digit_r     <= 1'b0;
      rej_r       <= 1'b0;
      fin_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      minus_r     <= minus_nxt;
      first_r     <= first_nxt;
      digit_r     <= digit_nxt;
      rej_r       <= rej_nxt;
      fin_valid_r <= fin_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r <= fin_nxt;
  end

endmodule

// ----- rtl/dip_out_stage.sv -----
// ----------------------------------------------------------------------------
// dip_out_stage: result register of the decimal integer parser
// Applies the final range checks of the mode, negates a minus number and
// holds the result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module dip_out_stage
  import dip_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fin_valid,
  input  fin_t        fin,
  output logic        fin_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_value,
  output logic        out_ok
);

  logic        valid_r, valid_nxt;
  logic [63:0] value_r;
  logic        ok_r;
  logic        ok;
  logic [63:0] value;

  assign fin_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_value = value_r;
  assign out_ok    = ok_r;

  always_comb begin
    ok = fin.ok_pre;
    case (fin.mode)
      MODE_S32: begin
        if (fin.acc > (fin.minus ? LIM_S32_NEG : LIM_S32_POS)) begin
          ok = 1'b0;
        end
      end
      MODE_U64: begin
        if (fin.minus) begin
          ok = 1'b0;
        end
      end
      MODE_U32: begin
        if (fin.minus || fin.acc > LIM_U32) begin
          ok = 1'b0;
        end
      end
      default: begin
        ok = ok;
      end
    endcase
    // A mode switch in mid-number can leave a positive magnitude above the
    // signed 64-bit maximum.
    if (!fin.mode[1] && !fin.minus && fin.acc > LIM_S64_POS) begin
      ok = 1'b0;
    end
    value = '0;
    if (ok) begin
      value = fin.minus ? (64'd0 - fin.acc) : fin.acc;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (fin_ready) begin
      valid_nxt = fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && fin_valid) begin
      value_r <= value;
      ok_r    <= ok;
    end
  end

endmodule

// ----- rtl/decimal_integer_parser.sv -----
// ----------------------------------------------------------------------------
// decimal_integer_parser: ASCII decimal text to 64-bit integer
// Parses one number per run of character beats, with overflow checking.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one character each in in_tdata, in_tuser set when the
//   character is present, and in_tlast on the final beat of the number. A
//   beat with in_tuser low carries no character; with in_tlast it closes the
//   number (alone, it is the empty string, which is rejected).
//   One result beat comes per number: out_tdata holds the value (two's
//   complement, zero when rejected), out_tuser is set when it was accepted.
//   cfg_wr_data selects the mode (signed 64, signed 32, unsigned 64,
//   unsigned 32); write it only while no number is in flight.
// Timing:
//   One character beat per cycle while in_tready is high. The pipeline is
//   input register, parse step with its hand-off register, result register:
//   a taken last character beat passes the hand-off and result registers to
//   become the result beat. The per-character step (multiply by ten as two
//   shifts and an add, plus a limit compare) sets the cycle.
// Reset and stalls:
//   Reset clears all stages and the parse state and selects signed 64-bit.
//   A stalled result holds its beat and one more finished number can wait
//   behind it; characters keep flowing until the last beat of a third
//   finished number reaches the parse step, then in_tready drops.
// ----------------------------------------------------------------------------
module decimal_integer_parser
  import dip_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] char_code
  input  logic        in_tuser,    // [0] has_char
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [63:0] parsed_value
  output logic        out_tuser,   // [0] accepted
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);

  mode_t mode_r, mode_nxt;
  item_t in_item, item;
  logic  item_valid, item_take;
  logic  fin_valid, fin_ready;
  fin_t  fin;

  assign in_item.char_code = in_tdata;
  assign in_item.has_char  = in_tuser;
  assign in_item.last_char = in_tlast;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_wr_en) begin
      mode_nxt = mode_t'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_S64;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  dip_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  dip_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .mode          (mode_r),
    .item_valid    (item_valid),
    .item          (item),
    .item_take     (item_take),
    .fin_valid     (fin_valid),
    .fin           (fin),
    .fin_ready_out (fin_ready)
  );

  dip_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin_valid (fin_valid),
    .fin       (fin),
    .fin_ready (fin_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (out_tdata),
    .out_ok    (out_tuser)
  );

`ifndef NO_ASSERTIONS
  a_reject_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 64'd0)
    else $error("rejected result beat carries a nonzero value");

  a_empty_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !item_valid |-> in_tready)
    else $error("input register empty but beat refused");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid && !fin_ready |=> fin_valid)
    else $error("finished number lost while result stage was full");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat valid right after reset");
`endif

endmodule
